### sv/sfct_pkg.sv
// Shared types, constants and helper functions of the swing-foot trajectory block.
package sfct_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int MUL_STEPS     = 33;
	localparam int NUM_AXES      = 3;

	localparam logic [31:0] PERIOD_RST = 32'd19661;
	localparam logic [31:0] LIFT_RST   = 32'd5243;

	localparam logic CFG_PERIOD = 1'b0;
	localparam logic CFG_LIFT   = 1'b1;

	localparam logic [1:0] KIND_AXIS = 2'd0;
	localparam logic [1:0] KIND_ROW  = 2'd1;
	localparam logic [1:0] KIND_EVAL = 2'd2;

	typedef enum logic {
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEG,
		ST_CHK,
		ST_DIV,
		ST_C1,
		ST_CF,
		ST_COEF_A,
		ST_COEF_B,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_ROT,
		ST_OUT
	} state_t;

	function automatic logic signed [63:0] sx64(input logic [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

	// Clamp a 64-bit signed value to the 32-bit signed range.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v[63:31] != {33{v[63]}}) begin
			return v[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		return v[31:0];
	endfunction

endpackage

### sv/sfct_alu.sv
// Shared bit-serial unit: signed shift-add multiply with floor shift, or restoring divide.
module sfct_alu #(
	parameter int FRAC_BITS = sfct_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sfct_pkg::alu_req_t req,
	input  logic signed [63:0] mul_a,
	input  logic [32:0]        mul_b,
	input  logic [31:0]        div_num,
	input  logic [31:0]        div_den,
	output logic               done,
	output logic signed [63:0] result
);

	localparam int CW = 6;

	logic                  busy_q;
	logic                  done_q;
	sfct_pkg::alu_op_t     op_q;
	logic [CW-1:0]         cnt_q;
	logic signed [63:0]    a_q;
	logic [32:0]           b_q;
	logic signed [63:0]    hi_q;
	logic [32:0]           lo_q;
	logic [32:0]           rem_q;
	logic [31:0]           den_q;
	logic [FRAC_BITS-1:0]  quo_q;

	logic                  last;
	logic signed [64:0]    a_ext;
	logic signed [64:0]    addend;
	logic signed [64:0]    psum;
	logic [33:0]           rem2;
	logic [33:0]           rdiff;
	logic                  ge;
	logic [96:0]           prod;

	always_comb begin
		last   = (cnt_q == CW'(1));
		a_ext  = {a_q[63], a_q};
		addend = '0;
		if (b_q[0]) begin
			// The top multiplier bit carries negative weight.
			addend = last ? -a_ext : a_ext;
		end
		psum   = {hi_q[63], hi_q} + addend;
		rem2   = {rem_q, 1'b0};
		ge     = (rem2 >= {2'b00, den_q});
		rdiff  = rem2 - {2'b00, den_q};
		prod   = {hi_q, lo_q};
		if (op_q == sfct_pkg::ALU_DIV) begin
			result = {{(64-FRAC_BITS){1'b0}}, quo_q};
		end else begin
			result = $signed(prod[FRAC_BITS +: 64]);
		end
	end

	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= sfct_pkg::ALU_MUL;
		end else begin
			done_q <= busy_q & last;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= (req.op == sfct_pkg::ALU_MUL) ? CW'(sfct_pkg::MUL_STEPS)
				                                        : CW'(FRAC_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= mul_a;
			b_q   <= mul_b;
			hi_q  <= '0;
			lo_q  <= '0;
			rem_q <= {1'b0, div_num};
			den_q <= div_den;
			quo_q <= '0;
		end else if (busy_q) begin
			if (op_q == sfct_pkg::ALU_MUL) begin
				hi_q <= psum[64:1];
				lo_q <= {psum[0], lo_q[32:1]};
				b_q  <= b_q >> 1;
			end else begin
				rem_q <= ge ? rdiff[32:0] : rem2[32:0];
				quo_q <= {quo_q[FRAC_BITS-2:0], ge};
			end
		end
	end

endmodule

### sv/swing_foot_cubic_trajectory.sv
// Top level of the swing-foot trajectory generator: stores, sequencer and output register.
// Load items are accepted only while idle and never raise in_stall. By default values carry
// 16 fraction bits. For an evaluate item the shared bit-serial unit runs one divide and five
// multiplies for each segment that runs its curve, none for a segment that holds its end
// value, and nine multiplies for the rotation.
// Only one item is in flight; in_stall is high from acceptance until the result is registered.
// Reset clears the endpoint stores, loads the identity rotation and the register defaults.
module swing_foot_cubic_trajectory #(
	parameter int FRAC_BITS = sfct_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         kind,
	input  logic [1:0]         slot,
	input  logic signed [31:0] begin_position,
	input  logic signed [31:0] begin_velocity,
	input  logic signed [31:0] finish_position,
	input  logic signed [31:0] finish_velocity,
	input  logic signed [31:0] row_col0,
	input  logic signed [31:0] row_col1,
	input  logic signed [31:0] row_col2,
	input  logic [31:0]        elapsed_time,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] foot_x,
	output logic signed [31:0] foot_y,
	output logic signed [31:0] foot_z,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data
);

	// One in fixed point, the diagonal of the reset rotation.
	localparam logic [31:0] ONE_FX = 32'd1 << FRAC_BITS;

	sfct_pkg::state_t state_q, state_d;

	// Configuration registers.
	logic [31:0] period_q;
	logic [31:0] lift_q;

	// Endpoint stores per axis and the rotation, row-major.
	logic [31:0] x0_st_q [3];
	logic [31:0] v0_st_q [3];
	logic [31:0] xf_st_q [3];
	logic [31:0] vf_st_q [3];
	logic [31:0] rot_st_q [3][3];

	// Sequencer control.
	logic       launched_q;
	logic [1:0] seg_q;
	logic [1:0] ri_q;
	logic [1:0] rj_q;
	logic       out_valid_q;

	// Working registers of one segment.
	logic [31:0]        t_q;
	logic [31:0]        tt_q;
	logic [31:0]        pp_q;
	logic signed [63:0] x0_q, v0_q, xf_q, vf_q;
	logic [32:0]        s_q;
	logic signed [63:0] c1_q, cf_q, d_q, e_q, c2_q, c3_q, acc_q;
	logic signed [31:0] pv_q [3];
	logic signed [63:0] sum_q;
	logic signed [31:0] rot_res_q [3];
	logic signed [31:0] foot_x_q, foot_y_q, foot_z_q;

	// Shared unit hookup.
	sfct_pkg::alu_req_t alu_req;
	logic signed [63:0] alu_a;
	logic [32:0]        alu_b;
	logic               alu_done;
	logic signed [63:0] alu_res;

	logic               accept;
	logic               out_free;
	logic               seg_last;
	logic               step_done;

	// Segment selection.
	logic signed [63:0] apex;
	logic [31:0]        half;
	logic signed [63:0] sel_x0, sel_v0, sel_xf, sel_vf;
	logic [31:0]        sel_t, sel_p;
	logic signed [63:0] rot_sum;
	logic [31:0]        rot_coef;

	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign seg_last  = (seg_q == 2'd2);
	assign step_done = launched_q && alu_done;
	assign in_stall  = (state_q != sfct_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign foot_x    = foot_x_q;
	assign foot_y    = foot_y_q;
	assign foot_z    = foot_z_q;

	// The Z axis splits at half the period: a rise to the apex with zero end velocity,
	// then a fall from the apex with zero start velocity to the stored end state.
	always_comb begin
		apex = sfct_pkg::sx64(x0_st_q[2]) + sfct_pkg::sx64(lift_q);
		half = {1'b0, period_q[31:1]};
		sel_x0 = sfct_pkg::sx64(x0_st_q[seg_q]);
		sel_v0 = sfct_pkg::sx64(v0_st_q[seg_q]);
		sel_xf = sfct_pkg::sx64(xf_st_q[seg_q]);
		sel_vf = sfct_pkg::sx64(vf_st_q[seg_q]);
		sel_t  = t_q;
		sel_p  = period_q;
		if (seg_last) begin
			if (t_q < half) begin
				sel_xf = apex;
				sel_vf = '0;
				sel_p  = half;
			end else begin
				sel_x0 = apex;
				sel_v0 = '0;
				sel_t  = t_q - half;
				sel_p  = period_q - half;
			end
		end
		rot_coef = rot_st_q[rj_q][ri_q];
		rot_sum  = sum_q + alu_res;
	end

	// Next state and shared unit requests.
	always_comb begin
		state_d       = state_q;
		alu_req.start = 1'b0;
		alu_req.op    = sfct_pkg::ALU_MUL;
		alu_a         = v0_q;
		alu_b         = {1'b0, pp_q};
		case (state_q)
			sfct_pkg::ST_IDLE: begin
				if (accept && kind == sfct_pkg::KIND_EVAL) begin
					state_d = sfct_pkg::ST_SEG;
				end
			end
			sfct_pkg::ST_SEG: begin
				state_d = sfct_pkg::ST_CHK;
			end
			sfct_pkg::ST_CHK: begin
				// At or past the period, or with an empty period, the end value holds.
				if (tt_q >= pp_q) begin
					state_d = seg_last ? sfct_pkg::ST_ROT : sfct_pkg::ST_SEG;
				end else begin
					state_d = sfct_pkg::ST_DIV;
				end
			end
			sfct_pkg::ST_DIV: begin
				alu_req.start = !launched_q;
				alu_req.op    = sfct_pkg::ALU_DIV;
				if (step_done) begin
					state_d = sfct_pkg::ST_C1;
				end
			end
			sfct_pkg::ST_C1: begin
				alu_req.start = !launched_q;
				if (step_done) begin
					state_d = sfct_pkg::ST_CF;
				end
			end
			sfct_pkg::ST_CF: begin
				alu_req.start = !launched_q;
				alu_a         = vf_q;
				if (step_done) begin
					state_d = sfct_pkg::ST_COEF_A;
				end
			end
			sfct_pkg::ST_COEF_A: begin
				state_d = sfct_pkg::ST_COEF_B;
			end
			sfct_pkg::ST_COEF_B: begin
				state_d = sfct_pkg::ST_M1;
			end
			sfct_pkg::ST_M1: begin
				alu_req.start = !launched_q;
				alu_a         = c3_q;
				alu_b         = s_q;
				if (step_done) begin
					state_d = sfct_pkg::ST_M2;
				end
			end
			sfct_pkg::ST_M2: begin
				alu_req.start = !launched_q;
				alu_a         = acc_q;
				alu_b         = s_q;
				if (step_done) begin
					state_d = sfct_pkg::ST_M3;
				end
			end
			sfct_pkg::ST_M3: begin
				alu_req.start = !launched_q;
				alu_a         = acc_q;
				alu_b         = s_q;
				if (step_done) begin
					state_d = seg_last ? sfct_pkg::ST_ROT : sfct_pkg::ST_SEG;
				end
			end
			sfct_pkg::ST_ROT: begin
				// Transposed rotation: output i sums R[j][i] * p[j] over j.
				alu_req.start = !launched_q;
				alu_a         = sfct_pkg::sx64(pv_q[rj_q]);
				alu_b         = {rot_coef[31], rot_coef};
				if (step_done && rj_q == 2'd2 && ri_q == 2'd2) begin
					state_d = sfct_pkg::ST_OUT;
				end
			end
			sfct_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = sfct_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sfct_pkg::ST_IDLE;
			end
		endcase
	end

	sfct_alu #(
		.FRAC_BITS (FRAC_BITS)
	) u_alu (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (alu_req),
		.mul_a   (alu_a),
		.mul_b   (alu_b),
		.div_num (tt_q),
		.div_den (pp_q),
		.done    (alu_done),
		.result  (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfct_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control state, configuration and stores.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launched_q  <= 1'b0;
			seg_q       <= '0;
			ri_q        <= '0;
			rj_q        <= '0;
			out_valid_q <= 1'b0;
			period_q    <= sfct_pkg::PERIOD_RST;
			lift_q      <= sfct_pkg::LIFT_RST;
			for (int i = 0; i < 3; i++) begin
				x0_st_q[i] <= '0;
				v0_st_q[i] <= '0;
				xf_st_q[i] <= '0;
				vf_st_q[i] <= '0;
				for (int j = 0; j < 3; j++) begin
					rot_st_q[i][j] <= (i == j) ? ONE_FX : '0;
				end
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					sfct_pkg::CFG_PERIOD: period_q <= cfg_data;
					sfct_pkg::CFG_LIFT:   lift_q   <= cfg_data;
					default: ;
				endcase
			end
			if (accept && slot < 2'(sfct_pkg::NUM_AXES)) begin
				case (kind)
					sfct_pkg::KIND_AXIS: begin
						x0_st_q[slot] <= begin_position;
						v0_st_q[slot] <= begin_velocity;
						xf_st_q[slot] <= finish_position;
						vf_st_q[slot] <= finish_velocity;
					end
					sfct_pkg::KIND_ROW: begin
						rot_st_q[slot][0] <= row_col0;
						rot_st_q[slot][1] <= row_col1;
						rot_st_q[slot][2] <= row_col2;
					end
					default: ;
				endcase
			end

			if (alu_req.start) begin
				launched_q <= 1'b1;
			end else if (alu_done) begin
				launched_q <= 1'b0;
			end

			if (state_q == sfct_pkg::ST_IDLE) begin
				seg_q <= '0;
				ri_q  <= '0;
				rj_q  <= '0;
			end
			if ((state_q == sfct_pkg::ST_CHK && tt_q >= pp_q) ||
			    (state_q == sfct_pkg::ST_M3 && step_done)) begin
				seg_q <= seg_q + 2'd1;
			end
			if (state_q == sfct_pkg::ST_ROT && step_done) begin
				if (rj_q == 2'd2) begin
					rj_q <= '0;
					ri_q <= ri_q + 2'd1;
				end else begin
					rj_q <= rj_q + 2'd1;
				end
			end

			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == sfct_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			t_q <= elapsed_time;
		end
		if (state_q == sfct_pkg::ST_IDLE) begin
			sum_q <= '0;
		end
		case (state_q)
			sfct_pkg::ST_SEG: begin
				x0_q <= sel_x0;
				v0_q <= sel_v0;
				xf_q <= sel_xf;
				vf_q <= sel_vf;
				tt_q <= sel_t;
				pp_q <= sel_p;
			end
			sfct_pkg::ST_CHK: begin
				if (tt_q >= pp_q) begin
					pv_q[seg_q] <= sfct_pkg::sat32(xf_q);
				end
			end
			sfct_pkg::ST_DIV: begin
				if (step_done) begin
					s_q <= alu_res[32:0];
				end
			end
			sfct_pkg::ST_C1: begin
				if (step_done) begin
					c1_q <= alu_res;
				end
			end
			sfct_pkg::ST_CF: begin
				if (step_done) begin
					cf_q <= alu_res;
				end
			end
			sfct_pkg::ST_COEF_A: begin
				d_q <= xf_q - x0_q;
				e_q <= c1_q + cf_q;
			end
			sfct_pkg::ST_COEF_B: begin
				// c2 = 3D - 2c1 - cf, c3 = c1 + cf - 2D.
				c2_q <= d_q + (d_q <<< 1) - e_q - c1_q;
				c3_q <= e_q - (d_q <<< 1);
			end
			sfct_pkg::ST_M1: begin
				if (step_done) begin
					acc_q <= c2_q + alu_res;
				end
			end
			sfct_pkg::ST_M2: begin
				if (step_done) begin
					acc_q <= c1_q + alu_res;
				end
			end
			sfct_pkg::ST_M3: begin
				if (step_done) begin
					pv_q[seg_q] <= sfct_pkg::sat32(x0_q + alu_res);
				end
			end
			sfct_pkg::ST_ROT: begin
				if (step_done) begin
					if (rj_q == 2'd2) begin
						rot_res_q[ri_q] <= sfct_pkg::sat32(rot_sum);
						sum_q           <= '0;
					end else begin
						sum_q <= rot_sum;
					end
				end
			end
			sfct_pkg::ST_OUT: begin
				if (out_free) begin
					foot_x_q <= rot_res_q[0];
					foot_y_q <= rot_res_q[1];
					foot_z_q <= rot_res_q[2];
				end
			end
			default: ;
		endcase
	end

endmodule
